### rtl/iar_pkg.sv
// Shared constants, types and helpers for the integer-to-ASCII radix converter.
// No dependencies; imported by iar_div, iar_store and int_to_ascii_radix.
package iar_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 6;
  localparam int FUNC_W      = 2;
  localparam int CHAR_W      = 7;

  // digits of the widest magnitude plus a minus sign
  localparam int STORE_DEPTH = VALUE_WIDTH + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int DCNT_W      = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [VALUE_WIDTH-1:0] S16_MAX  = VALUE_WIDTH'(32'h0000_7FFF);
  localparam logic [VALUE_WIDTH-1:0] HI_ONES  = {{(VALUE_WIDTH-16){1'b1}}, 16'h0000};

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
  // 'a' - 10
  localparam logic [CHAR_W-1:0] ALPHA_OFS  = 7'd87;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_S32 = 2'd0,
    FUNC_S16 = 2'd1,
    FUNC_U32 = 2'd2,
    FUNC_RSV = 2'd3
  } func_t;

  typedef struct packed {
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [CHAR_W-1:0]      wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
  } store_req_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < RADIX_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = ALPHA_OFS + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

### rtl/int_to_ascii_radix.sv
// Integer-to-ASCII radix converter, top level. Uses iar_pkg, iar_div, iar_store.
// Each digit takes one pass through the shared bit-serial divider, the minus sign
// takes the S_SIGN state, then each character emitted passes through S_RD and S_OUT.
// An invalid base answers with one transaction in the cycle after accept. One transaction at a time.
// Reset (rst_n low, synchronous) returns the sequencer to idle; the store is not cleared.
module int_to_ascii_radix (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [iar_pkg::VALUE_WIDTH-1:0] in_value_bits,
  input  logic [iar_pkg::RADIX_W-1:0]     in_radix,
  input  logic [iar_pkg::FUNC_W-1:0]      in_func,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [iar_pkg::CHAR_W-1:0]      out_char_code,
  output logic                            out_last,
  output logic                            out_empty_res
);
  import iar_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_SIGN  = 6'b000100,
    S_RD    = 6'b001000,
    S_OUT   = 6'b010000,
    S_EMPTY = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   neg_r, neg_nxt;
  logic [RADIX_W-1:0]     radix_r, radix_nxt;

  logic                   accept;
  logic                   radix_ok;
  func_t                  func;
  logic [VALUE_WIDTH-1:0] val_ext;
  logic                   val_neg;
  logic [VALUE_WIDTH-1:0] mag;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RADIX_W-1:0]     div_divisor;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [RADIX_W-1:0]     div_rem;

  store_req_t             st_req;
  logic [CHAR_W-1:0]      st_rd_data;

  assign func     = func_t'(in_func);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign radix_ok = in_radix inside {[RADIX_MIN:RADIX_MAX]};

  always_comb begin
    val_ext = in_value_bits;
    if (func == FUNC_S16 && in_value_bits > S16_MAX) begin
      val_ext = in_value_bits | HI_ONES;
    end
  end

  assign val_neg = (func != FUNC_U32) && val_ext[VALUE_WIDTH-1];
  assign mag     = val_neg ? (~val_ext + VALUE_WIDTH'(1)) : val_ext;

  // base comes from the port on accept, from the held copy on later digits
  assign div_divisor = (state_r == S_IDLE) ? in_radix : radix_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    neg_nxt      = neg_r;
    radix_nxt    = radix_r;
    div_start    = 1'b0;
    div_dividend = mag;
    st_req       = '0;
    st_req.wr_addr = cnt_r[ADDR_W-1:0];
    st_req.rd_addr = idx_r[ADDR_W-1:0];
    st_req.wr_data = digit_char(div_rem);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (radix_ok) begin
            div_start = 1'b1;
            neg_nxt   = val_neg;
            radix_nxt = in_radix;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_EMPTY;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          // digits land least significant first
          st_req.wr_en = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
          if (div_quo != '0) begin
            div_start    = 1'b1;
            div_dividend = div_quo;
          end else if (neg_r) begin
            state_nxt = S_SIGN;
          end else begin
            idx_nxt   = cnt_r;
            state_nxt = S_RD;
          end
        end
      end
      S_SIGN: begin
        st_req.wr_en   = 1'b1;
        st_req.wr_data = CHAR_MINUS;
        cnt_nxt        = cnt_r + CNT_W'(1);
        idx_nxt        = cnt_r;
        state_nxt      = S_RD;
      end
      S_RD: begin
        st_req.rd_en = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - CNT_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_EMPTY: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      neg_r   <= 1'b0;
      radix_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      neg_r   <= neg_nxt;
      radix_r <= radix_nxt;
    end
  end

  iar_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  iar_store u_store (
    .clk     (clk),
    .req     (st_req),
    .rd_data (st_rd_data)
  );

  assign out_valid     = (state_r == S_OUT) || (state_r == S_EMPTY);
  assign out_empty_res = (state_r == S_EMPTY);
  assign out_char_code = (state_r == S_EMPTY) ? CHAR_NUL : st_rd_data;
  assign out_last      = (state_r == S_EMPTY) || (idx_r == '0);

endmodule

### rtl/iar_div.sv
// Restoring divider: VALUE_WIDTH-bit dividend by a 6-bit base, one quotient bit a cycle.
// Depends on iar_pkg.
module iar_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [iar_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [iar_pkg::RADIX_W-1:0]  divisor,
  output logic                         done,
  output logic [iar_pkg::VALUE_WIDTH-1:0] quotient,
  output logic [iar_pkg::RADIX_W-1:0]  remainder
);
  import iar_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DCNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0]  quo_r, quo_nxt;
  logic [RADIX_W-1:0]      rem_r, rem_nxt;
  logic [RADIX_W-1:0]      base_r, base_nxt;
  logic [RADIX_W:0]        shifted;
  logic [RADIX_W:0]        diff;
  logic                    ge;

  // partial remainder stays below the base, so RADIX_W+1 bits hold the shift
  assign shifted = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign ge      = shifted >= {1'b0, base_r};
  assign diff    = shifted - {1'b0, base_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    base_nxt = base_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(VALUE_WIDTH - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      base_nxt = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], ge};
      rem_nxt = ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    base_r <= base_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/iar_store.sv
// Character store: one write port, one registered read port.
// Depends on iar_pkg.
module iar_store (
  input  logic                       clk,
  input  iar_pkg::store_req_t        req,
  output logic [iar_pkg::CHAR_W-1:0] rd_data
);
  import iar_pkg::*;

  logic [CHAR_W-1:0] mem [STORE_DEPTH];
  logic [CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### tb/iar_checker.sv
// Transaction checker for int_to_ascii_radix: predicts the text of every accepted request
// and compares each returned character against it. Depends on iar_pkg only.
module iar_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [iar_pkg::VALUE_WIDTH-1:0] in_value_bits,
  input  logic [iar_pkg::RADIX_W-1:0]     in_radix,
  input  logic [iar_pkg::FUNC_W-1:0]      in_func,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [iar_pkg::CHAR_W-1:0]      out_char_code,
  input  logic                            out_last,
  input  logic                            out_empty_res,
  output int                              fail_count,
  output int                              pending
);
  import iar_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              empty_res;
  } text_char_t;

  text_char_t text_q[$];
  int         errs = 0;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [VALUE_WIDTH-1:0] d);
    if (d < 10) begin
      return CHAR_W'(8'h30 + d);
    end
    return CHAR_W'(8'h61 + d - 10);
  endfunction

  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] raw,
                                       input logic [RADIX_W-1:0]     rdx,
                                       input logic [FUNC_W-1:0]      fn);
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] base;
    logic [CHAR_W-1:0]      lsd_first[$];
    bit                     neg;
    func_t                  mode;
    text_char_t             tc;
    mode = func_t'(fn);
    if (rdx < RADIX_MIN || rdx > RADIX_MAX) begin
      tc.char_code = CHAR_NUL;
      tc.last      = 1'b1;
      tc.empty_res = 1'b1;
      text_q.push_back(tc);
      return;
    end
    v = raw;
    if (mode == FUNC_S16 && v > S16_MAX) begin
      v = v | HI_ONES;
    end
    // unused mode three reads as signed full width
    neg  = (mode != FUNC_U32) && v[VALUE_WIDTH-1];
    mag  = neg ? (VALUE_WIDTH'(0) - v) : v;
    base = VALUE_WIDTH'(rdx);
    do begin
      lsd_first.push_back(digit_ascii(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (neg) begin
      lsd_first.push_back(CHAR_MINUS);
    end
    for (int k = lsd_first.size() - 1; k >= 0; k--) begin
      tc.char_code = lsd_first[k];
      tc.last      = (k == 0);
      tc.empty_res = 1'b0;
      text_q.push_back(tc);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      // results of earlier requests first; a new request cannot answer on its own accept edge
      if (out_valid && out_ready) begin
        if (text_q.size() == 0) begin
          $error("unexpected result transaction: char_code %h last %b empty_res %b",
                 out_char_code, out_last, out_empty_res);
          errs++;
        end else begin
          want = text_q.pop_front();
          if (out_char_code !== want.char_code) begin
            $error("char_code mismatch: expected %h, got %h", want.char_code, out_char_code);
            errs++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %b, got %b", want.last, out_last);
            errs++;
          end
          if (out_empty_res !== want.empty_res) begin
            $error("empty_res mismatch: expected %b, got %b", want.empty_res, out_empty_res);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_text(in_value_bits, in_radix, in_func);
      end
    end
    fail_count <= errs;
    pending    <= text_q.size();
  end

endmodule

### tb/tb_int_to_ascii_radix.sv
// Top of the int_to_ascii_radix testbench: clock, reset, request stimulus and result-side
// back-pressure. Depends on iar_pkg, int_to_ascii_radix and iar_checker.
module tb_int_to_ascii_radix;
  import iar_pkg::*;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   in_valid      = 1'b0;
  logic [VALUE_WIDTH-1:0] in_value_bits = '0;
  logic [RADIX_W-1:0]     in_radix      = '0;
  logic [FUNC_W-1:0]      in_func       = '0;
  logic                   out_ready     = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic [CHAR_W-1:0]      out_char_code;
  logic                   out_last;
  logic                   out_empty_res;

  int fail_count;
  int pending;
  bit calm       = 1'b0;
  int ready_hold = 0;

  int_to_ascii_radix u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value_bits (in_value_bits),
    .in_radix      (in_radix),
    .in_func       (in_func),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_empty_res (out_empty_res)
  );

  iar_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value_bits (in_value_bits),
    .in_radix      (in_radix),
    .in_func       (in_func),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result-side stalls in random bursts, counted down by ready_hold
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // valid stays high into the next request; only hold_off and drain_text lower it
  task automatic send_text_req(input logic [VALUE_WIDTH-1:0] v,
                               input logic [RADIX_W-1:0]     r,
                               input logic [FUNC_W-1:0]      f);
    in_valid      <= 1'b1;
    in_value_bits <= v;
    in_radix      <= r;
    in_func       <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic hold_off(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic random_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      hold_off($urandom_range(1, 3));
    end
  endtask

  // the checker's count is read only once it already includes the last accept
  task automatic drain_text();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [VALUE_WIDTH-1:0] v;
    logic [RADIX_W-1:0]     r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text_req(32'h0000_0000, 6'd10, FUNC_S32);
    send_text_req(32'hFFFF_FFFF, 6'd2,  FUNC_U32);
    send_text_req(32'hFFFF_FFFF, 6'd36, FUNC_U32);
    send_text_req(32'hFFFF_FFFF, 6'd10, FUNC_S32);
    random_gap();
    send_text_req(32'h8000_0000, 6'd2,  FUNC_S32);
    send_text_req(32'h8000_0000, 6'd10, FUNC_S32);
    send_text_req(32'h7FFF_FFFF, 6'd36, FUNC_S32);
    send_text_req(32'h7FFF_FFFF, 6'd2,  FUNC_U32);
    send_text_req(32'h0000_7FFF, 6'd10, FUNC_S16);
    random_gap();
    send_text_req(32'h0000_8000, 6'd10, FUNC_S16);
    send_text_req(32'h1234_5678, 6'd16, FUNC_S16);
    send_text_req(32'hFFFF_FFFF, 6'd8,  FUNC_S16);
    send_text_req(32'h8000_0000, 6'd16, FUNC_RSV);
    send_text_req(32'h0000_0023, 6'd36, FUNC_RSV);
    random_gap();
    send_text_req(32'h1234_5678, 6'd0,  FUNC_S32);
    send_text_req(32'hFFFF_FFFF, 6'd1,  FUNC_U32);
    send_text_req(32'h0000_0000, 6'd37, FUNC_S16);
    send_text_req(32'hAAAA_5555, 6'd63, FUNC_RSV);
    send_text_req(32'hDEAD_BEEF, 6'd16, FUNC_U32);
    send_text_req(32'h0000_0000, 6'd2,  FUNC_U32);
    send_text_req(32'h0000_0022, 6'd35, FUNC_S32);
    send_text_req(32'h5555_AAAA, 6'd3,  FUNC_S32);
    drain_text();

    for (int n = 0; n < 430; n++) begin
      calm <= (n >= 370) || (n >= 180 && n < 220);
      if (n == 215) begin
        drain_text();
      end
      case ($urandom_range(0, 5))
        0:       v = $urandom_range(0, 40);
        1:       v = 32'h8000_0000 | $urandom_range(0, 40);
        2:       v = 32'h0000_7FF0 + $urandom_range(0, 31);
        3:       v = 32'hFFFF_FFFF - $urandom_range(0, 40);
        4:       v = $urandom & 32'h0000_FFFF;
        default: v = $urandom;
      endcase
      case ($urandom_range(0, 19))
        0, 1:       r = RADIX_W'($urandom_range(0, 1));
        2:          r = RADIX_W'($urandom_range(37, 63));
        3, 4, 5, 6: begin
          case ($urandom_range(0, 4))
            0:       r = 6'd2;
            1:       r = 6'd8;
            2:       r = 6'd10;
            3:       r = 6'd16;
            default: r = 6'd36;
          endcase
        end
        default:    r = RADIX_W'($urandom_range(2, 36));
      endcase
      random_gap();
      send_text_req(v, r, FUNC_W'($urandom_range(0, 3)));
    end

    drain_text();
    repeat (64) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
